@@ hdl/rrq_pkg.sv @@
// Shared types and constants for the round-robin run queue.
package rrq_pkg;

    localparam int ID_W          = 6;
    localparam int ID_SPACE      = 1 << ID_W;
    localparam int SLICE_W       = 8;
    localparam int QCNT_W        = 7;
    localparam int IN_TDATA_W    = 8;
    localparam int OUT_TDATA_W   = 24;
    localparam int NUM_PROCS_DEF = 64;
    localparam logic [SLICE_W-1:0] MAX_SLICE_RST = 8'd5;

    typedef enum logic [1:0] {
        ACT_ENQ  = 2'd0,
        ACT_DEQ  = 2'd1,
        ACT_PICK = 2'd2,
        ACT_TICK = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_COMPACT
    } state_t;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic            enq;
        logic            deq;
        logic [ID_W-1:0] id;
    } cell_cmd_t;

    // what a cell shows its neighbours
    typedef struct packed {
        logic            occ;
        logic            hole;
        logic [ID_W-1:0] id;
    } cell_data_t;

endpackage

@@ hdl/rrq_cell.sv @@
// One queue position: holds an id, takes an append, and closes a dequeue gap.
module rrq_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  rrq_pkg::cell_cmd_t cmd,
    input  rrq_pkg::cell_data_t left,
    input  rrq_pkg::cell_data_t right,
    output rrq_pkg::cell_data_t data
);
    import rrq_pkg::*;

    logic            occ_reg;
    logic            hole_reg;
    logic [ID_W-1:0] id_reg;

    logic take_enq;
    logic take_right;

    // first empty position behind an occupied one gets the append
    assign take_enq   = cmd.enq && !occ_reg && left.occ;
    assign take_right = hole_reg && right.occ;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg  <= 1'b0;
            hole_reg <= 1'b0;
        end
        else if (take_enq)
        begin
            occ_reg <= 1'b1;
        end
        else if (cmd.deq && occ_reg && (id_reg == cmd.id))
        begin
            hole_reg <= 1'b1;
        end
        else if (hole_reg)
        begin
            // gap moves right; at the end of the run it becomes free
            hole_reg <= 1'b0;
            occ_reg  <= right.occ;
        end
        else if (left.hole && occ_reg)
        begin
            hole_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_enq)
        begin
            id_reg <= cmd.id;
        end
        else if (take_right)
        begin
            id_reg <= right.id;
        end
    end

    assign data.occ  = occ_reg;
    assign data.hole = hole_reg;
    assign data.id   = id_reg;

endmodule

@@ hdl/rrq_slice_mem.sv @@
// Time-slice table: one read port and one write port, with per-entry valid bits (unwritten entries read zero).
module rrq_slice_mem #(
    parameter int DEPTH = rrq_pkg::NUM_PROCS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        rd_en,
    input  logic [$clog2(DEPTH)-1:0]    rd_addr,
    output logic [rrq_pkg::SLICE_W-1:0] rd_data,
    input  logic                        wr_en,
    input  logic [$clog2(DEPTH)-1:0]    wr_addr,
    input  logic [rrq_pkg::SLICE_W-1:0] wr_data
);
    import rrq_pkg::*;

    logic [SLICE_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]   vld_reg;
    logic [SLICE_W-1:0] rd_data_reg;
    logic               rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule

@@ hdl/round_robin_run_queue.sv @@
// Round-robin run queue with per-process time slices, built as a chain of cells.
//
//  channel   | dir | handshake                 | contents
//  ----------+-----+---------------------------+------------------------------------
//  s_*       | in  | s_tvalid / s_tready       | action [1:0], proc_id [7:2]
//  m_*       | out | m_tvalid / m_tready       | accepted, pick_valid, pick_id,
//            |     |                           | resched, queue_count, slice
//  cfg_*     | in  | cfg_we (no wait)          | slice limit [7:0]
//
//  Sequence: an item is taken while idle and its result is registered in the
//  execute state once the output register is free; pick, tick, enqueue and
//  refused actions then return to idle, while a dequeue holds the input in
//  the compact state as the gap walks one cell a cycle to the tail of the chain.
//  Stalls: a finished result sits in the output register; the block holds the
//  next item in execution until that register is free.
//  Reset: the chain, membership bits and slice valid bits clear at once.
module round_robin_run_queue #(
    parameter int NUM_PROCS = rrq_pkg::NUM_PROCS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration
    input  logic                            cfg_we,
    input  logic [rrq_pkg::SLICE_W-1:0]     cfg_wdata,   // slice limit
    // input items
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [rrq_pkg::IN_TDATA_W-1:0]  s_tdata,     // action[1:0], proc_id[7:2]
    // result items
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [rrq_pkg::OUT_TDATA_W-1:0] m_tdata      // accepted[0], pick_valid[1],
                                                         // pick_id[7:2], resched[8],
                                                         // queue_count[15:9], slice[23:16]
);
    import rrq_pkg::*;

    // only ids that fit in proc_id can ever be queued
    localparam int SLOTS  = (NUM_PROCS < ID_SPACE) ? NUM_PROCS : ID_SPACE;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);

    state_t state_reg, state_next;

    logic [SLICE_W-1:0] max_slice_reg;
    action_t            act_reg;
    logic [ID_W-1:0]    id_reg;
    logic               vid_reg;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [SLOTS-1:0]   inq_reg;

    logic                   out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;

    logic               accept_in;
    logic               out_free;
    logic               commit;
    logic               inq_hit;
    logic [SLOT_W-1:0]  slot;

    logic [SLICE_W-1:0] slice_cur;
    logic [SLICE_W-1:0] slice_new;
    logic               slice_wr;
    logic               acc;
    logic               pick_v;
    logic [ID_W-1:0]    pick_id;
    logic               resched;
    logic [SLICE_W-1:0] slice_out;

    cell_cmd_t          cmd;
    cell_data_t         cells    [SLOTS];
    cell_data_t         left_in  [SLOTS];
    cell_data_t         right_in [SLOTS];
    logic [SLOTS-1:0]   occ_vec;
    logic [SLOTS-1:0]   hole_vec;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept_in = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign commit    = (state_reg == ST_EXEC) && out_free;
    assign slot      = SLOT_W'(id_reg);
    assign inq_hit   = vid_reg && inq_reg[slot];

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_slice_reg <= MAX_SLICE_RST;
        end
        else if (cfg_we)
        begin
            max_slice_reg <= cfg_wdata;
        end
    end

    // latched item
    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            act_reg <= action_t'(s_tdata[1:0]);
            id_reg  <= s_tdata[7:2];
            vid_reg <= (32'(s_tdata[7:2]) < NUM_PROCS);
        end
    end

    rrq_slice_mem #(
        .DEPTH (SLOTS)
    ) u_slice (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept_in),
        .rd_addr (SLOT_W'(s_tdata[7:2])),
        .rd_data (slice_cur),
        .wr_en   (commit && slice_wr),
        .wr_addr (slot),
        .wr_data (slice_new)
    );

    // action decode, evaluated in the execute cycle
    always_comb
    begin
        slice_new = slice_cur;
        slice_wr  = 1'b0;
        acc       = 1'b0;
        pick_v    = 1'b0;
        pick_id   = '0;
        resched   = 1'b0;
        cnt_next  = cnt_reg;
        cmd.enq   = 1'b0;
        cmd.deq   = 1'b0;
        cmd.id    = id_reg;
        case (act_reg)
            ACT_ENQ:
            begin
                if (vid_reg && !inq_hit)
                begin
                    acc      = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                    cmd.enq  = commit;
                    slice_wr = 1'b1;
                    if ((slice_cur == '0) || (slice_cur > max_slice_reg))
                    begin
                        slice_new = max_slice_reg;
                    end
                end
            end
            ACT_DEQ:
            begin
                if (inq_hit)
                begin
                    acc      = 1'b1;
                    cnt_next = cnt_reg - 1'b1;
                    cmd.deq  = commit;
                end
            end
            ACT_PICK:
            begin
                // head is reported even for an out-of-range id
                if (cnt_reg != '0)
                begin
                    pick_v  = 1'b1;
                    pick_id = cells[0].id;
                end
            end
            ACT_TICK:
            begin
                if (vid_reg)
                begin
                    slice_wr = 1'b1;
                    if (slice_cur != '0)
                    begin
                        slice_new = slice_cur - 1'b1;
                    end
                    resched = (slice_new == '0);
                end
            end
            default:
            begin
                slice_wr = 1'b0;
            end
        endcase
        slice_out = vid_reg ? slice_new : '0;
    end

    // membership bits and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inq_reg <= '0;
            cnt_reg <= '0;
        end
        else if (commit && acc)
        begin
            cnt_reg       <= cnt_next;
            inq_reg[slot] <= (act_reg == ACT_ENQ);
        end
    end

    // chain of cells, head at index 0
    generate
        for (genvar i = 0; i < SLOTS; i++)
        begin : g_cell
            if (i == 0)
            begin : g_head
                assign left_in[i] = '{occ: 1'b1, hole: 1'b0, id: '0};
            end
            else
            begin : g_mid
                assign left_in[i] = cells[i-1];
            end
            if (i == SLOTS - 1)
            begin : g_tail
                assign right_in[i] = '{occ: 1'b0, hole: 1'b0, id: '0};
            end
            else
            begin : g_next
                assign right_in[i] = cells[i+1];
            end

            rrq_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .cmd   (cmd),
                .left  (left_in[i]),
                .right (right_in[i]),
                .data  (cells[i])
            );

            assign occ_vec[i]  = cells[i].occ;
            assign hole_vec[i] = cells[i].hole;
        end
    endgenerate

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept_in)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (commit)
                begin
                    state_next = cmd.deq ? ST_COMPACT : ST_IDLE;
                end
            end
            ST_COMPACT:
            begin
                if (!(|hole_vec))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            out_data_reg <= {slice_out, QCNT_W'(cnt_next), resched, pick_id, pick_v, acc};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // checks
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cnt_reg) <= SLOTS)
        else $error("queue count beyond chain length");

    a_idle_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !(|hole_vec))
        else $error("gap left in chain while idle");

    a_members: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> ($countones(inq_reg) == 32'(cnt_reg)))
        else $error("membership bits disagree with count");

    a_cells: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> ($countones(occ_vec) == 32'(cnt_reg)))
        else $error("occupied cells disagree with count");

    a_head: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (cells[0].occ == (cnt_reg != '0)))
        else $error("head cell state disagrees with count");

endmodule
